FILE: rtl/hbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

   // Mode codes
   localparam logic [1:0] MODE_BIMODAL = 2'd0;
   localparam logic [1:0] MODE_GSHARE  = 2'd1;
   localparam logic [1:0] MODE_HYBRID  = 2'd2;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_MODE         = 3'd0;
   localparam logic [2:0] CSR_BIMODAL_BITS = 3'd1;
   localparam logic [2:0] CSR_GSHARE_BITS  = 3'd2;
   localparam logic [2:0] CSR_HISTORY_BITS = 3'd3;
   localparam logic [2:0] CSR_CHOOSER_BITS = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;

   // Counter encodings
   localparam logic [2:0] CTR_INIT    = 3'd4;
   localparam logic [2:0] CTR_MAX     = 3'd7;
   localparam logic [1:0] CHOOSE_INIT = 2'd1;
   localparam logic [1:0] CHOOSE_MAX  = 2'd3;

   localparam int MISS_W = 32;

   // One result beat
   typedef struct packed {
      logic              predicted_taken;
      logic              mispredicted;
      logic              bimodal_guess;
      logic              gshare_guess;
      logic              chose_gshare;
      logic [MISS_W-1:0] miss_count;
   } rsp_type;

   // 3-bit saturating counter step
   function automatic logic [2:0] ctr_train(logic [2:0] ctr, logic t);
      logic [2:0] res;
      res = ctr;
      if (t) begin
         if (ctr != CTR_MAX) res = ctr + 3'd1;
      end else begin
         if (ctr != 3'd0) res = ctr - 3'd1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hybrid_branch_predictor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A result beat is registered in stage 1, then written to the result queue.
// Throughput: one branch per cycle while the result queue has room; the table
// read-modify-write is a RAM read, then update and write-back, with forwarding.
// Reset: synchronous; after reset a clearing pass writes all 2**MAX_INDEX_BITS
// entries (4096 by default) of the three tables, with req_ready low meanwhile.
module hybrid_branch_predictor_top #(
   parameter int MAX_INDEX_BITS = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [31:0]                     req_pc,
   input  wire logic                            req_taken,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_predicted_taken,
   output logic                                 rsp_mispredicted,
   output logic                                 rsp_bimodal_guess,
   output logic                                 rsp_gshare_guess,
   output logic                                 rsp_chose_gshare,
   output logic [hbp_pkg::MISS_W-1:0]           rsp_miss_count,
   input  wire logic                            csr_we,
   input  wire logic [hbp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW    = MAX_INDEX_BITS;
   localparam int DEPTH = 1 << IW;
   localparam int WB    = $clog2(IW + 1);
   localparam int QD    = 3;

   function automatic logic [WB-1:0] width_clamp(logic [3:0] w);
      logic [WB-1:0] res;
      if (w == 4'd0) res = WB'(1);
      else if (32'(w) > IW) res = WB'(IW);
      else res = WB'(w);
      return res;
   endfunction

   function automatic logic [IW-1:0] low_mask(logic [WB-1:0] w);
      return ~({IW{1'b1}} << w);
   endfunction

   // ---------------- configuration registers ----------------
   logic [1:0] mode_ff;
   logic [3:0] bim_bits_ff, gsh_bits_ff, hist_bits_ff, cho_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= hbp_pkg::MODE_BIMODAL;
         bim_bits_ff  <= 4'd12;
         gsh_bits_ff  <= 4'd12;
         hist_bits_ff <= 4'd4;
         cho_bits_ff  <= 4'd12;
      end else if (csr_we) begin
         unique case (csr_index)
            hbp_pkg::CSR_MODE:         mode_ff      <= csr_wdata[1:0];
            hbp_pkg::CSR_BIMODAL_BITS: bim_bits_ff  <= csr_wdata;
            hbp_pkg::CSR_GSHARE_BITS:  gsh_bits_ff  <= csr_wdata;
            hbp_pkg::CSR_HISTORY_BITS: hist_bits_ff <= csr_wdata;
            hbp_pkg::CSR_CHOOSER_BITS: cho_bits_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective widths and masks
   logic [WB-1:0] bim_w, gsh_w, hist_n;
   logic [IW-1:0] bim_mask, gsh_mask, cho_mask, hist_mask;

   always_comb begin
      bim_w  = width_clamp(bim_bits_ff);
      gsh_w  = width_clamp(gsh_bits_ff);
      if (32'(hist_bits_ff) > 32'(gsh_w)) hist_n = gsh_w;
      else hist_n = WB'(hist_bits_ff);
      bim_mask  = low_mask(bim_w);
      gsh_mask  = low_mask(gsh_w);
      cho_mask  = low_mask(width_clamp(cho_bits_ff));
      hist_mask = low_mask(hist_n);
   end

   // Mode decode; the spare code behaves as hybrid
   logic mode_bim, mode_gsh, mode_hyb;

   always_comb begin
      mode_bim = 1'b0;
      mode_gsh = 1'b0;
      mode_hyb = 1'b0;
      unique case (mode_ff)
         hbp_pkg::MODE_BIMODAL: mode_bim = 1'b1;
         hbp_pkg::MODE_GSHARE:  mode_gsh = 1'b1;
         default:               mode_hyb = 1'b1;
      endcase
   end

   // ---------------- clearing pass ----------------
   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic          clr_done_ff, clr_done_in;

   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_idx_in = clr_idx_ff + IW'(1);
         if (clr_idx_ff == {IW{1'b1}}) clr_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clr_done_ff <= clr_done_in;
      end
   end

   // ---------------- accept stage: indices, history ----------------
   logic          accept;
   logic [IW-1:0] addr, bim_idx, gsh_idx, cho_idx;
   logic [IW-1:0] hist_ff, hist_in;

   assign accept = req_valid && req_ready;

   always_comb begin
      addr    = req_pc[2 +: IW];
      bim_idx = addr & bim_mask;
      gsh_idx = (addr & gsh_mask) ^ (hist_ff & hist_mask);
      cho_idx = addr & cho_mask;
      // Outcome enters at the top of the active history
      hist_in = hist_ff;
      if (accept && !mode_bim) begin
         if (hist_n == '0) begin
            hist_in = '0;
         end else begin
            hist_in = (hist_ff & hist_mask) >> 1;
            if (req_taken) hist_in = hist_in | (IW'(1) << (hist_n - WB'(1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) hist_ff <= '0;
      else hist_ff <= hist_in;
   end

   // Stage 1 registers
   logic          s1_valid_ff;
   logic          s1_taken_ff, s1_bim_ff, s1_gsh_ff, s1_hyb_ff;
   logic [IW-1:0] s1_bi_ff, s1_gi_ff, s1_ci_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_taken_ff <= req_taken;
         s1_bim_ff   <= mode_bim;
         s1_gsh_ff   <= mode_gsh;
         s1_hyb_ff   <= mode_hyb;
         s1_bi_ff    <= bim_idx;
         s1_gi_ff    <= gsh_idx;
         s1_ci_ff    <= cho_idx;
      end
   end

   // ---------------- tables ----------------
   logic          bim_we, gsh_we, cho_we;
   logic [IW-1:0] bim_wa, gsh_wa, cho_wa;
   logic [2:0]    bim_wd, gsh_wd;
   logic [1:0]    cho_wd;
   logic [2:0]    bim_rd, gsh_rd;
   logic [1:0]    cho_rd;

   hbp_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_bim_ram (
      .clock   (clock),
      .wr_en   (bim_we),
      .wr_addr (bim_wa),
      .wr_data (bim_wd),
      .rd_en   (accept),
      .rd_addr (bim_idx),
      .rd_data (bim_rd)
   );

   hbp_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_gsh_ram (
      .clock   (clock),
      .wr_en   (gsh_we),
      .wr_addr (gsh_wa),
      .wr_data (gsh_wd),
      .rd_en   (accept),
      .rd_addr (gsh_idx),
      .rd_data (gsh_rd)
   );

   hbp_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cho_ram (
      .clock   (clock),
      .wr_en   (cho_we),
      .wr_addr (cho_wa),
      .wr_data (cho_wd),
      .rd_en   (accept),
      .rd_addr (cho_idx),
      .rd_data (cho_rd)
   );

   // Last cycle's write-back, forwarded to a read that was issued alongside it
   logic          fb_valid_ff, fg_valid_ff, fc_valid_ff;
   logic [IW-1:0] fb_addr_ff, fg_addr_ff, fc_addr_ff;
   logic [2:0]    fb_data_ff, fg_data_ff;
   logic [1:0]    fc_data_ff;

   // ---------------- stage 1: predict, train, write back ----------------
   logic [2:0]  bim_ctr, gsh_ctr;
   logic [1:0]  cho_ctr, cho_new;
   logic        bg, gg, use_g, pred, miss;
   logic        bim_train, gsh_train;
   logic [hbp_pkg::MISS_W-1:0] miss_cnt_ff, miss_cnt_in;
   hbp_pkg::rsp_type           s1_rsp;

   always_comb begin
      bim_ctr = (fb_valid_ff && fb_addr_ff == s1_bi_ff) ? fb_data_ff : bim_rd;
      gsh_ctr = (fg_valid_ff && fg_addr_ff == s1_gi_ff) ? fg_data_ff : gsh_rd;
      cho_ctr = (fc_valid_ff && fc_addr_ff == s1_ci_ff) ? fc_data_ff : cho_rd;

      bg    = bim_ctr[2];
      gg    = gsh_ctr[2];
      use_g = s1_hyb_ff && cho_ctr[1];
      if (s1_bim_ff) pred = bg;
      else if (s1_gsh_ff) pred = gg;
      else pred = use_g ? gg : bg;
      miss = pred != s1_taken_ff;

      bim_train = s1_valid_ff && (s1_bim_ff || (s1_hyb_ff && !use_g));
      gsh_train = s1_valid_ff && (s1_gsh_ff || use_g);

      // Chooser leans toward whichever component alone was right
      cho_new = cho_ctr;
      if (gg == s1_taken_ff && bg != s1_taken_ff) begin
         if (cho_ctr != hbp_pkg::CHOOSE_MAX) cho_new = cho_ctr + 2'd1;
      end else if (gg != s1_taken_ff && bg == s1_taken_ff) begin
         if (cho_ctr != 2'd0) cho_new = cho_ctr - 2'd1;
      end

      miss_cnt_in = miss_cnt_ff;
      if (s1_valid_ff && miss && miss_cnt_ff != {hbp_pkg::MISS_W{1'b1}}) begin
         miss_cnt_in = miss_cnt_ff + hbp_pkg::MISS_W'(1);
      end

      s1_rsp.predicted_taken = pred;
      s1_rsp.mispredicted    = miss;
      s1_rsp.bimodal_guess   = bg;
      s1_rsp.gshare_guess    = gg;
      s1_rsp.chose_gshare    = use_g;
      s1_rsp.miss_count      = miss_cnt_in;
   end

   // Write port select: clearing pass or training
   always_comb begin
      if (!clr_done_ff) begin
         bim_we = 1'b1;
         gsh_we = 1'b1;
         cho_we = 1'b1;
         bim_wa = clr_idx_ff;
         gsh_wa = clr_idx_ff;
         cho_wa = clr_idx_ff;
         bim_wd = hbp_pkg::CTR_INIT;
         gsh_wd = hbp_pkg::CTR_INIT;
         cho_wd = hbp_pkg::CHOOSE_INIT;
      end else begin
         bim_we = bim_train;
         gsh_we = gsh_train;
         cho_we = s1_valid_ff && s1_hyb_ff;
         bim_wa = s1_bi_ff;
         gsh_wa = s1_gi_ff;
         cho_wa = s1_ci_ff;
         bim_wd = hbp_pkg::ctr_train(bim_ctr, s1_taken_ff);
         gsh_wd = hbp_pkg::ctr_train(gsh_ctr, s1_taken_ff);
         cho_wd = cho_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_valid_ff <= 1'b0;
         fg_valid_ff <= 1'b0;
         fc_valid_ff <= 1'b0;
         miss_cnt_ff <= '0;
      end else begin
         fb_valid_ff <= clr_done_ff && bim_we;
         fg_valid_ff <= clr_done_ff && gsh_we;
         fc_valid_ff <= clr_done_ff && cho_we;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fb_addr_ff <= bim_wa;
      fg_addr_ff <= gsh_wa;
      fc_addr_ff <= cho_wa;
      fb_data_ff <= bim_wd;
      fg_data_ff <= gsh_wd;
      fc_data_ff <= cho_wd;
   end

   // ---------------- result queue ----------------
   hbp_pkg::rsp_type q_ff [QD];
   logic [1:0] q_wr_ff, q_rd_ff, q_cnt_ff;
   logic [1:0] q_wr_in, q_rd_in, q_cnt_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = q_cnt_ff != 2'd0;
   assign req_ready = clr_done_ff && ((3'(q_cnt_ff) + 3'(s1_valid_ff)) < 3'(QD));

   always_comb begin
      q_wr_in  = q_wr_ff;
      q_rd_in  = q_rd_ff;
      q_cnt_in = q_cnt_ff;
      if (s1_valid_ff) q_wr_in = (q_wr_ff == 2'(QD - 1)) ? 2'd0 : q_wr_ff + 2'd1;
      if (pop) q_rd_in = (q_rd_ff == 2'(QD - 1)) ? 2'd0 : q_rd_ff + 2'd1;
      if (s1_valid_ff && !pop) q_cnt_in = q_cnt_ff + 2'd1;
      else if (!s1_valid_ff && pop) q_cnt_in = q_cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) q_ff[q_wr_ff] <= s1_rsp;
   end

   assign rsp_predicted_taken = q_ff[q_rd_ff].predicted_taken;
   assign rsp_mispredicted    = q_ff[q_rd_ff].mispredicted;
   assign rsp_bimodal_guess   = q_ff[q_rd_ff].bimodal_guess;
   assign rsp_gshare_guess    = q_ff[q_rd_ff].gshare_guess;
   assign rsp_chose_gshare    = q_ff[q_rd_ff].chose_gshare;
   assign rsp_miss_count      = q_ff[q_rd_ff].miss_count;

   // ---------------- assertions ----------------
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_cnt_ff != 2'd3))
      else $error("result queue has no room for stage 1 beat");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      !clr_done_ff |-> !req_ready)
      else $error("beat accepted during clearing pass");

   a_stage1_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted beat did not reach stage 1");

   a_miss_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (miss_cnt_ff >= $past(miss_cnt_ff)))
      else $error("miss count went backward");

endmodule

`default_nettype wire

FILE: rtl/hbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hbp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
